/* rtl/cfp_pkg.sv */
// Shared constants, types and helper functions for the command frame parser.
package cfp_pkg;

    // Message geometry
    localparam int MAX_MESSAGE_BYTES = 255;
    localparam int POS_W             = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int CAPTURE_BYTES     = 14;
    localparam int HASH_START        = 9;
    localparam int HASH_START_EDIT   = 10;

    // Byte positions inside the message
    localparam int POS_KIND          = 0;
    localparam int POS_CODE          = 4;
    localparam int POS_CODE_EDIT     = 5;
    localparam int POS_GET_PIN       = 9;
    localparam int POS_SET_PIN       = 10;
    localparam int POS_SET_LEVEL     = 12;
    localparam int POS_EDIT_PIN      = 11;
    localparam int POS_EDIT_LEVEL    = 13;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [7:0]  CHAR_BIAS = 8'd49;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_CHAR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GET_CHAR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_CHAR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_CHAR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_CHAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STATE_CHAR = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALL_CHAR   = 3'd6;

    // Match character reset values (ASCII S G E P I S A)
    localparam logic [7:0] RST_SET_CHAR   = 8'd83;
    localparam logic [7:0] RST_GET_CHAR   = 8'd71;
    localparam logic [7:0] RST_EDIT_CHAR  = 8'd69;
    localparam logic [7:0] RST_POST_CHAR  = 8'd80;
    localparam logic [7:0] RST_INFO_CHAR  = 8'd73;
    localparam logic [7:0] RST_STATE_CHAR = 8'd83;
    localparam logic [7:0] RST_ALL_CHAR   = 8'd65;

    // Command kinds and codes
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_EDIT  = 2'd2;
    localparam logic [1:0] KIND_POST  = 2'd3;
    localparam logic [1:0] SEL_INFO   = 2'd0;
    localparam logic [1:0] SEL_STATE  = 2'd1;
    localparam logic [1:0] SEL_ALL    = 2'd2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t set_char;
        byte_t get_char;
        byte_t edit_char;
        byte_t post_char;
        byte_t info_char;
        byte_t state_char;
        byte_t all_char;
    } cfg_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  kind;
        logic [1:0]  code;
        byte_t       pin;
        byte_t       level;
        logic [31:0] hash;
    } result_t;

    // Remove the ASCII '1' bias, wrapping at 8 bits
    function automatic byte_t minus_bias(input byte_t b);
        return b - CHAR_BIAS;
    endfunction

    // One djb2 step: h * 33 + b, modulo 2^32
    function automatic logic [31:0] hash_step(input logic [31:0] h, input byte_t b);
        return (h << 5) + h + {24'd0, b};
    endfunction

endpackage

/* rtl/cfp_if.sv */
// Valid/ready channel interfaces for message bytes and parse results.
interface cfp_byte_if;
    import cfp_pkg::*;
    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface cfp_result_if;
    import cfp_pkg::*;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [1:0]  kind;
    logic [1:0]  code;
    byte_t       pin;
    byte_t       level;
    logic [31:0] hash;

    modport source (output valid, output ok, output kind, output code, output pin,
                    output level, output hash, input ready);
    modport sink   (input valid, input ok, input kind, input code, input pin,
                    input level, input hash, output ready);
endinterface

/* rtl/cfp_decode.sv */
// Command decoder: match kind and code bytes and build the next result.
module cfp_decode
    import cfp_pkg::*;
(
    input  cfg_t        cfg,
    input  byte_t       cap [CAPTURE_BYTES],
    input  logic [31:0] hash9,
    input  logic [31:0] hash10,
    input  result_t     prev,
    output result_t     res
);

    byte_t first;
    byte_t c4;
    byte_t c5;

    assign first = cap[POS_KIND];
    assign c4    = cap[POS_CODE];
    assign c5    = cap[POS_CODE_EDIT];

    // Try kinds in order set, get, edit, post; unset fields keep earlier values
    always_comb
    begin
        res      = prev;
        res.ok   = 1'b0;
        res.hash = HASH_SEED;
        priority if (first == cfg.set_char)
        begin
            res.kind = KIND_SET;
            priority if (c4 == cfg.info_char)
            begin
                res.code = SEL_INFO;
                res.hash = hash9;
                res.ok   = 1'b1;
            end
            else if (c4 == cfg.state_char)
            begin
                res.code  = SEL_STATE;
                res.pin   = minus_bias(cap[POS_SET_PIN]);
                res.level = minus_bias(cap[POS_SET_LEVEL]);
                res.ok    = 1'b1;
            end
            else
            begin
                res.ok = 1'b0;
            end
        end
        else if (first == cfg.get_char)
        begin
            res.kind = KIND_GET;
            priority if (c4 == cfg.all_char)
            begin
                res.code = SEL_ALL;
                res.ok   = 1'b1;
            end
            else if (c4 == cfg.info_char)
            begin
                res.code = SEL_INFO;
                res.hash = hash9;
                res.ok   = 1'b1;
            end
            else if (c4 == cfg.state_char)
            begin
                res.code = SEL_STATE;
                res.pin  = minus_bias(cap[POS_GET_PIN]);
                res.ok   = 1'b1;
            end
            else
            begin
                res.ok = 1'b0;
            end
        end
        else if (first == cfg.edit_char)
        begin
            res.kind = KIND_EDIT;
            priority if (c5 == cfg.info_char)
            begin
                res.code = SEL_INFO;
                res.hash = hash10;
                res.ok   = 1'b1;
            end
            else if (c5 == cfg.state_char)
            begin
                res.code  = SEL_STATE;
                res.pin   = minus_bias(cap[POS_EDIT_PIN]);
                res.level = minus_bias(cap[POS_EDIT_LEVEL]);
                res.ok    = 1'b1;
            end
            else
            begin
                res.ok = 1'b0;
            end
        end
        else if (first == cfg.post_char)
        begin
            res.kind = KIND_POST;
            res.ok   = 1'b1;
        end
        else
        begin
            res.ok = 1'b0;
        end
    end

endmodule

/* rtl/command_frame_parser_djb_hash_top.sv */
// Command frame parser top level: input register, message capture, result register.
// Datapath: the final byte of a message moves from the input register to the result register,
// whose contents show on the result channel as the result of that message.
// Throughput: one byte per cycle; the hash update and decode fit between the two registers.
// The input stalls only when a final byte waits for a result register that is still held.
// Reset: match characters return to their ASCII defaults, the message state clears,
// the held result fields go to zero with hash 5381; there is no clearing pass.
module command_frame_parser_djb_hash_top
    import cfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  byte_t                cfg_data,
    cfp_byte_if.sink             msg,
    cfp_result_if.source         res
);

    cfg_t              cfg_reg;
    logic              a_valid_reg;
    byte_t             a_byte_reg;
    logic              a_last_reg;
    logic              a_advance;
    logic [POS_W-1:0]  pos_reg;
    byte_t             cap_reg [CAPTURE_BYTES];
    byte_t             cap_next [CAPTURE_BYTES];
    logic [31:0]       hash9_reg;
    logic [31:0]       hash10_reg;
    logic [31:0]       hash9_next;
    logic [31:0]       hash10_next;
    logic              in_range;
    result_t           res_reg;
    result_t           res_next;
    logic              res_valid_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_char   <= RST_SET_CHAR;
            cfg_reg.get_char   <= RST_GET_CHAR;
            cfg_reg.edit_char  <= RST_EDIT_CHAR;
            cfg_reg.post_char  <= RST_POST_CHAR;
            cfg_reg.info_char  <= RST_INFO_CHAR;
            cfg_reg.state_char <= RST_STATE_CHAR;
            cfg_reg.all_char   <= RST_ALL_CHAR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SET_CHAR:   cfg_reg.set_char   <= cfg_data;
                CFG_GET_CHAR:   cfg_reg.get_char   <= cfg_data;
                CFG_EDIT_CHAR:  cfg_reg.edit_char  <= cfg_data;
                CFG_POST_CHAR:  cfg_reg.post_char  <= cfg_data;
                CFG_INFO_CHAR:  cfg_reg.info_char  <= cfg_data;
                CFG_STATE_CHAR: cfg_reg.state_char <= cfg_data;
                CFG_ALL_CHAR:   cfg_reg.all_char   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Advance the input stage unless a final byte must wait for the result register
    assign a_advance = a_valid_reg && (!a_last_reg || !res_valid_reg || res.ready);
    assign msg.ready = !a_valid_reg || a_advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (msg.valid && msg.ready)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (msg.valid && msg.ready)
        begin
            a_byte_reg <= msg.data_byte;
            a_last_reg <= msg.end_of_message;
        end
    end

    // Capture and hash updates for the byte in the input register
    assign in_range = pos_reg < POS_W'(MAX_MESSAGE_BYTES);

    always_comb
    begin
        for (int i = 0; i < CAPTURE_BYTES; i++)
        begin
            cap_next[i] = (in_range && pos_reg == POS_W'(i)) ? a_byte_reg : cap_reg[i];
        end
    end

    assign hash9_next  = (in_range && pos_reg >= POS_W'(HASH_START))
                         ? hash_step(hash9_reg, a_byte_reg) : hash9_reg;
    assign hash10_next = (in_range && pos_reg >= POS_W'(HASH_START_EDIT))
                         ? hash_step(hash10_reg, a_byte_reg) : hash10_reg;

    // Message state: advance on each byte up to the message limit, clear after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            hash9_reg  <= HASH_SEED;
            hash10_reg <= HASH_SEED;
            for (int i = 0; i < CAPTURE_BYTES; i++)
            begin
                cap_reg[i] <= '0;
            end
        end
        else if (a_advance)
        begin
            if (a_last_reg)
            begin
                pos_reg    <= '0;
                hash9_reg  <= HASH_SEED;
                hash10_reg <= HASH_SEED;
                for (int i = 0; i < CAPTURE_BYTES; i++)
                begin
                    cap_reg[i] <= '0;
                end
            end
            else
            begin
                if (in_range)
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
                hash9_reg  <= hash9_next;
                hash10_reg <= hash10_next;
                cap_reg    <= cap_next;
            end
        end
    end

    cfp_decode u_decode (
        .cfg    (cfg_reg),
        .cap    (cap_next),
        .hash9  (hash9_next),
        .hash10 (hash10_next),
        .prev   (res_reg),
        .res    (res_next)
    );

    // Result register; its fields also hold the values kept between messages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_reg.ok    <= 1'b0;
            res_reg.kind  <= KIND_SET;
            res_reg.code  <= SEL_INFO;
            res_reg.pin   <= '0;
            res_reg.level <= '0;
            res_reg.hash  <= HASH_SEED;
        end
        else if (a_advance && a_last_reg)
        begin
            res_valid_reg <= 1'b1;
            res_reg       <= res_next;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign res.valid = res_valid_reg;
    assign res.ok    = res_reg.ok;
    assign res.kind  = res_reg.kind;
    assign res.code  = res_reg.code;
    assign res.pin   = res_reg.pin;
    assign res.level = res_reg.level;
    assign res.hash  = res_reg.hash;

    // Input stalls only behind a final byte blocked by a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !msg.ready |-> (a_valid_reg && a_last_reg && res_valid_reg && !res.ready))
        else $error("input stalled without a blocked final byte");

    // A new result appears only after a final byte left the input stage
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(a_advance && a_last_reg))
        else $error("result raised without a final byte");

    // A failed parse carries the seed hash
    a_fail_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.ok) |-> (res_reg.hash == HASH_SEED))
        else $error("failed parse carries a computed hash");

    // Byte count never passes the message limit
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(MAX_MESSAGE_BYTES))
        else $error("byte position past the message limit");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the command frame parser: byte stimulus, result prediction, checks.
module tb;
    import cfp_pkg::*;

    typedef struct {
        byte_t data;
        logic  last;
    } msg_byte_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    byte_t                cfg_data;

    cfp_byte_if   msg_ch ();
    cfp_result_if res_ch ();

    command_frame_parser_djb_hash_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .msg       (msg_ch),
        .res       (res_ch)
    );

    // Stimulus and expectation stores
    msg_byte_t pending_bytes [$];
    result_t   expected_results [$];
    int        queued_total   = 0;
    int        accepted_bytes = 0;
    int        results_seen   = 0;
    int        error_count    = 0;

    // Idling control
    logic calm         = 1'b0;
    logic hold_request = 1'b0;
    logic hold_done    = 1'b0;
    int   src_gap      = 0;
    int   sink_gap     = 0;
    int   long_hold    = 0;

    // Predictor state: match characters and parser registers
    byte_t       cfg_chars [0:6];
    int          msg_len;
    byte_t       cap_bytes [0:CAPTURE_BYTES-1];
    logic [31:0] run_hash9;
    logic [31:0] run_hash10;
    logic [1:0]  kind_held;
    logic [1:0]  code_held;
    byte_t       pin_held;
    byte_t       level_held;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                      results_seen, name, got, want));
    endtask

    // Clear the per-message capture and running hashes
    task automatic clear_capture();
        msg_len    = 0;
        run_hash9  = HASH_SEED;
        run_hash10 = HASH_SEED;
        foreach (cap_bytes[i])
            cap_bytes[i] = 8'd0;
    endtask

    // Track one accepted byte; on the final byte decode and queue the expected result
    task automatic track_message_byte(input byte_t b, input logic last);
        result_t     r;
        logic        ok_v;
        logic [31:0] h;
        if (msg_len < MAX_MESSAGE_BYTES)
        begin
            if (msg_len < CAPTURE_BYTES)
                cap_bytes[msg_len] = b;
            if (msg_len >= HASH_START)
                run_hash9 = run_hash9 * 32'd33 + {24'd0, b};
            if (msg_len >= HASH_START_EDIT)
                run_hash10 = run_hash10 * 32'd33 + {24'd0, b};
            msg_len++;
        end
        if (last)
        begin
            h    = HASH_SEED;
            ok_v = 1'b0;
            if (cap_bytes[POS_KIND] == cfg_chars[CFG_SET_CHAR])
            begin
                kind_held = KIND_SET;
                if (cap_bytes[POS_CODE] == cfg_chars[CFG_INFO_CHAR])
                begin
                    code_held = SEL_INFO;
                    h         = run_hash9;
                    ok_v      = 1'b1;
                end
                else if (cap_bytes[POS_CODE] == cfg_chars[CFG_STATE_CHAR])
                begin
                    code_held  = SEL_STATE;
                    pin_held   = cap_bytes[POS_SET_PIN] - CHAR_BIAS;
                    level_held = cap_bytes[POS_SET_LEVEL] - CHAR_BIAS;
                    ok_v       = 1'b1;
                end
            end
            else if (cap_bytes[POS_KIND] == cfg_chars[CFG_GET_CHAR])
            begin
                kind_held = KIND_GET;
                if (cap_bytes[POS_CODE] == cfg_chars[CFG_ALL_CHAR])
                begin
                    code_held = SEL_ALL;
                    ok_v      = 1'b1;
                end
                else if (cap_bytes[POS_CODE] == cfg_chars[CFG_INFO_CHAR])
                begin
                    code_held = SEL_INFO;
                    h         = run_hash9;
                    ok_v      = 1'b1;
                end
                else if (cap_bytes[POS_CODE] == cfg_chars[CFG_STATE_CHAR])
                begin
                    code_held = SEL_STATE;
                    pin_held  = cap_bytes[POS_GET_PIN] - CHAR_BIAS;
                    ok_v      = 1'b1;
                end
            end
            else if (cap_bytes[POS_KIND] == cfg_chars[CFG_EDIT_CHAR])
            begin
                kind_held = KIND_EDIT;
                if (cap_bytes[POS_CODE_EDIT] == cfg_chars[CFG_INFO_CHAR])
                begin
                    code_held = SEL_INFO;
                    h         = run_hash10;
                    ok_v      = 1'b1;
                end
                else if (cap_bytes[POS_CODE_EDIT] == cfg_chars[CFG_STATE_CHAR])
                begin
                    code_held  = SEL_STATE;
                    pin_held   = cap_bytes[POS_EDIT_PIN] - CHAR_BIAS;
                    level_held = cap_bytes[POS_EDIT_LEVEL] - CHAR_BIAS;
                    ok_v       = 1'b1;
                end
            end
            else if (cap_bytes[POS_KIND] == cfg_chars[CFG_POST_CHAR])
            begin
                kind_held = KIND_POST;
                ok_v      = 1'b1;
            end
            r.ok    = ok_v;
            r.kind  = kind_held;
            r.code  = code_held;
            r.pin   = pin_held;
            r.level = level_held;
            r.hash  = h;
            expected_results.push_back(r);
            clear_capture();
        end
    endtask

    // Driver: advance to the next pending byte when the current one is taken
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        msg_byte_t item;
        logic      nv;
        if (!rst_n)
        begin
            msg_ch.valid          <= 1'b0;
            msg_ch.data_byte      <= 8'd0;
            msg_ch.end_of_message <= 1'b0;
        end
        else
        begin
            if (msg_ch.valid && msg_ch.ready)
            begin
                track_message_byte(msg_ch.data_byte, msg_ch.end_of_message);
                accepted_bytes++;
            end
            if (!msg_ch.valid || msg_ch.ready)
            begin
                nv = 1'b0;
                if (src_gap > 0)
                    src_gap--;
                else if (pending_bytes.size() > 0)
                begin
                    item = pending_bytes.pop_front();
                    nv   = 1'b1;
                    msg_ch.data_byte      <= item.data;
                    msg_ch.end_of_message <= item.last;
                    if (!calm && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 10);
                end
                msg_ch.valid <= nv;
            end
        end
    end

    // Monitor: check each result transaction and drive ready with stalls
    always @(posedge clk or negedge rst_n)
    begin : monitor_proc
        result_t want;
        logic    nr;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result %0d with no expectation waiting",
                                              results_seen));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("ok", res_ch.ok, want.ok);
                    check_field("kind", res_ch.kind, want.kind);
                    check_field("code", res_ch.code, want.code);
                    check_field("pin", res_ch.pin, want.pin);
                    check_field("level", res_ch.level, want.level);
                    check_field("hash", res_ch.hash, want.hash);
                end
                results_seen++;
            end
            nr = 1'b0;
            if (long_hold > 0)
                long_hold--;
            else if (hold_request && !hold_done)
            begin
                long_hold = 300;
                hold_done = 1'b1;
            end
            else if (sink_gap > 0)
                sink_gap--;
            else
            begin
                nr = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    sink_gap = $urandom_range(1, 10);
            end
            res_ch.ready <= nr;
        end
    end

    // Queue one message, flagging its final byte
    task automatic add_message(input byte_t body[$]);
        msg_byte_t item;
        foreach (body[i])
        begin
            item.data = body[i];
            item.last = (i == body.size() - 1);
            pending_bytes.push_back(item);
            queued_total++;
        end
    endtask

    // Build a well-formed command with random content, or noise, or a truncated one
    task automatic add_random_message(input int force_len);
        byte_t body[$];
        int    len;
        int    kind_sel;
        int    code_sel;
        int    code_pos;
        byte_t kind_ch;
        byte_t code_ch;
        if (force_len == 0 && $urandom_range(0, 99) < 15)
        begin
            len = $urandom_range(1, 16);
            repeat (len) body.push_back(byte_t'($urandom));
        end
        else
        begin
            kind_sel = (force_len > 0) ? 0 : $urandom_range(0, 3);
            code_sel = (force_len > 0) ? 0 : $urandom_range(0, 2);
            code_pos = (kind_sel == 2) ? POS_CODE_EDIT : POS_CODE;
            case (kind_sel)
                0:       kind_ch = cfg_chars[CFG_SET_CHAR];
                1:       kind_ch = cfg_chars[CFG_GET_CHAR];
                2:       kind_ch = cfg_chars[CFG_EDIT_CHAR];
                default: kind_ch = cfg_chars[CFG_POST_CHAR];
            endcase
            case (code_sel)
                0:       code_ch = cfg_chars[CFG_INFO_CHAR];
                1:       code_ch = cfg_chars[CFG_STATE_CHAR];
                default: code_ch = cfg_chars[CFG_ALL_CHAR];
            endcase
            if ($urandom_range(0, 9) == 0)
                code_ch = byte_t'($urandom);
            if (force_len > 0)
                len = force_len;
            else if (kind_sel == 3)
                len = $urandom_range(1, 8);
            else if (code_sel == 0)
                len = code_pos + 5 + $urandom_range(0, 8);
            else if (code_sel == 1)
                len = ((kind_sel == 0) ? 13 : (kind_sel == 1) ? 10 : 14) + $urandom_range(0, 3);
            else
                len = code_pos + 1 + $urandom_range(0, 4);
            if (force_len == 0 && $urandom_range(0, 9) == 0)
                len = $urandom_range(1, len);
            repeat (len) body.push_back(byte_t'($urandom));
            body[0] = kind_ch;
            if (len > code_pos)
                body[code_pos] = code_ch;
        end
        add_message(body);
    endtask

    // Write all seven match characters while the block is idle
    task automatic write_chars(input byte_t s, input byte_t g, input byte_t e, input byte_t p,
                               input byte_t i, input byte_t st, input byte_t a);
        byte_t vals [0:6];
        vals = '{s, g, e, p, i, st, a};
        for (int k = 0; k < 7; k++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data  <= vals[k];
            cfg_chars[k] = vals[k];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (accepted_bytes != queued_total || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic fill_random(input int budget);
        int start;
        start = queued_total;
        while (queued_total - start < budget)
            add_random_message(0);
    endtask

    // Main sequence: reset, directed messages, then random phases over several settings
    initial
    begin : main_seq
        byte_t body[$];
        int    n;
        msg_ch.valid          = 1'b0;
        msg_ch.data_byte      = 8'd0;
        msg_ch.end_of_message = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_SET_CHAR;
        cfg_data              = 8'd0;
        rst_n                 = 1'b0;
        cfg_chars = '{RST_SET_CHAR, RST_GET_CHAR, RST_EDIT_CHAR, RST_POST_CHAR,
                      RST_INFO_CHAR, RST_STATE_CHAR, RST_ALL_CHAR};
        kind_held  = KIND_SET;
        code_held  = SEL_INFO;
        pin_held   = 8'd0;
        level_held = 8'd0;
        clear_capture();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: one-byte post, unknown first bytes at both extremes
        body = '{cfg_chars[CFG_POST_CHAR]};
        add_message(body);
        body = '{8'h00};
        add_message(body);
        body = '{8'hFF};
        add_message(body);
        // Get all, then get with an unknown code byte
        body = '{cfg_chars[CFG_GET_CHAR], 8'h00, 8'h00, 8'h00, cfg_chars[CFG_ALL_CHAR]};
        add_message(body);
        body = '{cfg_chars[CFG_GET_CHAR], 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        add_message(body);
        // Set info ending before the hash bytes: hash stays at the seed
        body = '{cfg_chars[CFG_SET_CHAR], 8'h00, 8'hFF, 8'h00, cfg_chars[CFG_INFO_CHAR]};
        add_message(body);
        // Short edit: code byte never received reads as zero
        body = '{cfg_chars[CFG_EDIT_CHAR], 8'h31};
        add_message(body);
        // Short set state: pin and level bytes read as zero and wrap
        body = '{cfg_chars[CFG_SET_CHAR], 8'h7F, 8'h80, 8'h01, cfg_chars[CFG_STATE_CHAR]};
        add_message(body);
        fill_random(80);
        wait_idle();

        // Lowest extreme: every match character zero, all overlapping
        write_chars(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        fill_random(80);
        hold_request = 1'b1;
        wait_idle();

        // Highest extreme
        write_chars(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        fill_random(80);
        wait_idle();

        // Random characters, plus one message past the message limit
        write_chars(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                    byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
                    byte_t'($urandom));
        fill_random(40);
        add_random_message(MAX_MESSAGE_BYTES + 7);
        fill_random(40);
        wait_idle();

        // Back to the default characters, no idling on either side
        calm = 1'b1;
        write_chars(RST_SET_CHAR, RST_GET_CHAR, RST_EDIT_CHAR, RST_POST_CHAR,
                    RST_INFO_CHAR, RST_STATE_CHAR, RST_ALL_CHAR);
        fill_random(80);

        // Drain with a bound, then let the pipeline settle
        n = 0;
        while ((accepted_bytes != queued_total || expected_results.size() != 0) && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_results.size()));
        repeat (5) @(posedge clk);

        $display("Covered %0d bytes and %0d results over five character settings,",
                 accepted_bytes, results_seen);
        $display("including overlapping characters, a long message and a long result stall.");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

/* sim.f */
rtl/cfp_pkg.sv
rtl/cfp_if.sv
rtl/cfp_decode.sv
rtl/command_frame_parser_djb_hash_top.sv
tb/tb.sv
